[rtl/sorted_time_index_lookup_defines.svh]
// Assertion macros for the sorted time index lookup.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SORTED_TIME_INDEX_LOOKUP_DEFINES_SVH
`define SORTED_TIME_INDEX_LOOKUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sti_pkg.sv]
`default_nettype none

package sti_pkg;

  localparam int STAMP_W  = 32;
  localparam int OFFSET_W = 48;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [STAMP_W-1:0]  stamp;
    logic [OFFSET_W-1:0] entry_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] found_offset;
  } out_item_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

endpackage

`default_nettype wire

[rtl/sti_mem.sv]
`default_nettype none

module sti_mem #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output sti_pkg::entry_t      rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  sti_pkg::entry_t      wr_data
);
  import sti_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/sti_ctrl.sv]
`default_nettype none

module sti_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10,
  parameter int CW       = 11
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  sti_pkg::in_item_t    req,
  output logic                 busy,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  sti_pkg::entry_t      mem_rdata,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output sti_pkg::entry_t      mem_wr_data,
  output logic                 resp_valid,
  input  wire logic            resp_ready,
  output sti_pkg::out_item_t   resp
);
  import sti_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_START    = 8'b0000_0010,
    S_LK_FIRST = 8'b0000_0100,
    S_LK_LAST  = 8'b0000_1000,
    S_SEARCH   = 8'b0001_0000,
    S_FETCH    = 8'b0010_0000,
    S_SHIFT    = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  in_item_t            req_r, req_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [AW-1:0]       w_r, w_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [OFFSET_W-1:0] first_off_r, first_off_nxt;
  out_item_t           resp_r, resp_nxt;

  logic [CW-1:0]       mid_ext;
  logic [CW-1:0]       s_lo, s_hi, left;
  logic                hit;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW:1];
  endfunction

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    w_nxt         = w_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    first_off_nxt = first_off_r;
    resp_nxt      = resp_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = mem_rdata;
    mid_ext       = CW'(mid_r);
    s_lo          = lo_r;
    s_hi          = hi_r;
    left          = '0;
    hit           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          state_nxt = S_START;
        end
      end

      S_START: begin
        resp_nxt.found_offset = '0;
        resp_nxt.status       = ST_OK;
        unique case (req_r.action)
          ACT_INSERT: begin
            if (count_r >= CW'(CAPACITY)) begin
              resp_nxt.status = ST_FULL;
              state_nxt       = S_RESP;
            end else begin
              lo_nxt = '0;
              hi_nxt = count_r;
              if (count_r == '0) begin
                w_nxt     = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = mid_of('0, count_r);
                mid_nxt     = mid_of('0, count_r);
                state_nxt   = S_SEARCH;
              end
            end
          end
          ACT_LOOKUP: begin
            if (count_r == '0) begin
              resp_nxt.status = ST_MISS;
              state_nxt       = S_RESP;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = S_LK_FIRST;
            end
          end
          ACT_CLEAR: begin
            count_nxt = '0;
            state_nxt = S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_LK_FIRST: begin
        if (req_r.stamp < mem_rdata.stamp) begin
          resp_nxt.status = ST_MISS;
          state_nxt       = S_RESP;
        end else begin
          first_off_nxt = mem_rdata.offset;
          mem_rd_en     = 1'b1;
          mem_rd_addr   = AW'(count_r - CW'(1));
          state_nxt     = S_LK_LAST;
        end
      end

      S_LK_LAST: begin
        if (req_r.stamp > mem_rdata.stamp) begin
          resp_nxt.status = ST_MISS;
          state_nxt       = S_RESP;
        end else if (count_r <= CW'(2)) begin
          resp_nxt.found_offset = first_off_r;
          state_nxt             = S_RESP;
        end else begin
          lo_nxt      = '0;
          hi_nxt      = count_r;
          mem_rd_en   = 1'b1;
          mem_rd_addr = mid_of('0, count_r);
          mid_nxt     = mid_of('0, count_r);
          state_nxt   = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // Narrow the interval with the entry read last cycle, then probe the next mid.
        if (req_r.action == ACT_INSERT) begin
          if (mem_rdata.stamp <= req_r.stamp) begin
            s_lo = mid_ext + CW'(1);
          end else begin
            s_hi = mid_ext;
          end
        end else if (req_r.stamp == mem_rdata.stamp) begin
          hit = 1'b1;
        end else if (req_r.stamp < mem_rdata.stamp) begin
          s_hi = mid_ext;
        end else begin
          s_lo = mid_ext + CW'(1);
        end
        lo_nxt = s_lo;
        hi_nxt = s_hi;
        if (hit) begin
          resp_nxt.found_offset = mem_rdata.offset;
          state_nxt             = S_RESP;
        end else if (s_lo < s_hi) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = mid_of(s_lo, s_hi);
          mid_nxt     = mid_of(s_lo, s_hi);
        end else if (req_r.action == ACT_INSERT) begin
          w_nxt     = AW'(count_r);
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          left = (s_lo >= count_r) ? count_r - CW'(1) : s_lo;
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(left);
          state_nxt   = S_FETCH;
        end
      end

      S_FETCH: begin
        resp_nxt.found_offset = mem_rdata.offset;
        state_nxt             = S_RESP;
      end

      S_SHIFT: begin
        // Move entries up by one, top first, then write the new entry; the read of w-1 never meets the write of w+1.
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pend_addr_r;
          mem_wr_data = mem_rdata;
        end
        if (CW'(w_r) > lo_r) begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = w_r - AW'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = w_r;
          w_nxt         = w_r - AW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_wr_en          = 1'b1;
          mem_wr_addr        = w_r;
          mem_wr_data.stamp  = req_r.stamp;
          mem_wr_data.offset = req_r.entry_offset;
          count_nxt          = count_r + CW'(1);
          state_nxt          = S_RESP;
        end
      end

      S_RESP: begin
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    w_r         <= w_nxt;
    pend_addr_r <= pend_addr_nxt;
    first_off_r <= first_off_nxt;
    resp_r      <= resp_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign resp_valid = (state_r == S_RESP);
  assign resp       = resp_r;

endmodule

`default_nettype wire

[rtl/sorted_time_index_lookup.sv]
// Sorted time index lookup: one table of (stamp, offset) entries kept in
// ascending stamp order in a single-port-read, single-port-write memory.
// Input channel in_valid/in_stall/in_data: action 0 inserts, 1 looks up,
// 2 clears. Result channel out_valid/out_stall/out_data: one result per item.
// One item is worked at a time; in_stall is high from the cycle after a
// transfer until the item's result is handed to the output register.
// Every probe of the binary search is one registered memory read. Lookup steps:
// start, two range probes (first and last entry), search, final read and
// hand-over; a miss at a range probe or a hit in the search skips ahead to
// hand-over, and a table of two entries or fewer skips search and final read.
// Insert steps: start, search, one move up by one per entry above the new
// slot, the write of the new entry and hand-over, so an append moves no entry
// and an insert at the front of a nearly full table moves every entry. Clear,
// unused codes, a lookup in an empty table and an insert into a full table
// go straight from start to hand-over. Reset empties the table at once (no
// clearing pass); memory contents are not touched. While out_stall is high,
// a valid result in the output register holds; the next item is still
// taken and worked, and only its result waits until the register frees.
`default_nettype none

module sorted_time_index_lookup #(
  parameter int CAPACITY = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  sti_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output sti_pkg::out_item_t   out_data
);
  import sti_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          busy;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  logic          resp_valid, resp_ready;
  out_item_t     resp;
  logic          out_valid_r;
  out_item_t     out_data_r;

  sti_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid && !in_stall),
    .req         (in_data),
    .busy        (busy),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rdata   (rd_data),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .resp_valid  (resp_valid),
    .resp_ready  (resp_ready),
    .resp        (resp)
  );

  sti_mem #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_stall   = busy;
  assign resp_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load only when the register is free or its transfer completes.
  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_data_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/sti_checker.sv]
`default_nettype none
`include "sorted_time_index_lookup_defines.svh"

module sti_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input sti_pkg::out_item_t out_data
);
  import sti_pkg::*;

  logic in_fire;
  logic out_held;
  logic out_miss;

  assign in_fire  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_miss = out_valid && (out_data.status != ST_OK);

  `STI_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "result changed")
  `STI_ASSERT_NOW(a_status_legal, out_valid, out_data.status <= ST_FULL, "illegal status")
  `STI_ASSERT_NOW(a_zero_offset, out_miss, out_data.found_offset == '0, "offset not zero")
  `STI_ASSERT_NEXT(a_one_at_a_time, in_fire, in_stall, "second item taken")

endmodule

bind sorted_time_index_lookup sti_checker u_sti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[verif/testbench.sv]
module testbench;
  import sti_pkg::*;

  localparam int TABLE_DEPTH     = 1024;
  localparam int STAMP_STEP      = 60 * 60 / 10;
  localparam int RANDOM_ITEMS    = 400;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int SETTLE_CYCLES   = 64;

  // Action code that the block treats as a no-op
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Predicted contents of the index table
  logic [STAMP_W-1:0]  model_stamps [TABLE_DEPTH];
  logic [OFFSET_W-1:0] model_offsets [TABLE_DEPTH];
  int                  model_count = 0;

  out_item_t pending_results [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;
  bit hold_off_req = 1'b0;
  int stall_mode   = 0;
  int mode_left    = 0;
  int stall_tick   = 0;

  sorted_time_index_lookup #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t apply_to_index(in_item_t it);
    out_item_t res;
    int        lo;
    int        hi;
    int        mid;
    bit        hit;
    res.status       = ST_OK;
    res.found_offset = '0;
    case (it.action)
      ACT_INSERT: begin
        if (model_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // upper bound: new entry lands after any equal stamps
          lo = 0;
          hi = model_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (model_stamps[mid] <= it.stamp) lo = mid + 1;
            else hi = mid;
          end
          for (int i = model_count; i > lo; i--) begin
            model_stamps[i]  = model_stamps[i - 1];
            model_offsets[i] = model_offsets[i - 1];
          end
          model_stamps[lo]  = it.stamp;
          model_offsets[lo] = it.entry_offset;
          model_count++;
        end
      end
      ACT_LOOKUP: begin
        if (model_count == 0 || it.stamp < model_stamps[0] ||
            it.stamp > model_stamps[model_count - 1]) begin
          res.status = ST_MISS;
        end else if (model_count <= 2) begin
          res.found_offset = model_offsets[0];
        end else begin
          // stop at the first equal stamp probed, else take the next later entry
          lo  = 0;
          hi  = model_count;
          hit = 1'b0;
          while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (it.stamp == model_stamps[mid]) begin
              res.found_offset = model_offsets[mid];
              hit = 1'b1;
            end else if (it.stamp < model_stamps[mid]) begin
              hi = mid;
            end else begin
              lo = mid + 1;
            end
          end
          if (!hit) begin
            if (lo >= model_count) lo = model_count - 1;
            res.found_offset = model_offsets[lo];
          end
        end
      end
      ACT_CLEAR: model_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] act, logic [STAMP_W-1:0] stamp,
                                         logic [OFFSET_W-1:0] ofs);
    in_item_t it;
    it.action       = act;
    it.stamp        = stamp;
    it.entry_offset = ofs;
    return it;
  endfunction

  function automatic logic [OFFSET_W-1:0] rand_offset();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[OFFSET_W-1:0];
  endfunction

  // Exact hits, stamps between entries, just outside the range, or anywhere
  function automatic logic [STAMP_W-1:0] pick_lookup_stamp();
    int k;
    if (model_count == 0) return $urandom;
    k = $urandom_range(0, model_count - 1);
    case ($urandom_range(0, 5))
      0, 1:    return model_stamps[k];
      2:       return model_stamps[k] + $urandom_range(1, STAMP_STEP);
      3:       return model_stamps[0] - 1;
      4:       return model_stamps[model_count - 1] + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_to_index(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_edges();
    send_item(make_item(ACT_LOOKUP, '0, '0));
    send_item(make_item(ACT_INSERT, '0, '0));
    send_item(make_item(ACT_LOOKUP, '0, '1));
    send_item(make_item(ACT_LOOKUP, 32'd1, '0));
    send_item(make_item(ACT_INSERT, '1, '1));
    // two entries: any in-range time returns the first offset
    send_item(make_item(ACT_LOOKUP, 32'h8000_0000, '0));
    send_item(make_item(ACT_INSERT, 32'd1000, 48'h0000_0000_0A0A));
    send_item(make_item(ACT_INSERT, 32'd1000, 48'h0000_0000_0B0B));
    send_item(make_item(ACT_INSERT, STAMP_STEP, rand_offset()));
    send_item(make_item(ACT_LOOKUP, 32'd1000, '0));
    send_item(make_item(ACT_LOOKUP, 32'd999, '0));
    send_item(make_item(ACT_LOOKUP, 32'd1001, '0));
    send_item(make_item(ACT_LOOKUP, '1, '0));
    send_item(make_item(ACT_LOOKUP, '0, '0));
    send_item(make_item(ACT_UNUSED, $urandom, rand_offset()));
    send_item(make_item(ACT_CLEAR, $urandom, rand_offset()));
    send_item(make_item(ACT_LOOKUP, 32'd1000, '0));
    send_item(make_item(ACT_INSERT, 32'd5000, rand_offset()));
    send_item(make_item(ACT_INSERT, 32'd5000 + STAMP_STEP, rand_offset()));
    send_item(make_item(ACT_INSERT, 32'd5000 + 2 * STAMP_STEP, rand_offset()));
    send_item(make_item(ACT_LOOKUP, 32'd4999, '0));
    send_item(make_item(ACT_LOOKUP, 32'd5001, '0));
    send_item(make_item(ACT_LOOKUP, 32'd5000 + 2 * STAMP_STEP, '0));
  endtask

  task automatic test_fill_to_capacity();
    logic [STAMP_W-1:0] next_stamp;
    send_item(make_item(ACT_CLEAR, '0, '0));
    next_stamp = $urandom_range(1, 1 << 20);
    while (model_count < TABLE_DEPTH) begin
      if (model_count == TABLE_DEPTH - 1) begin
        // last free slot goes to the front, so every entry moves up
        send_item(make_item(ACT_INSERT, '0, rand_offset()));
      end else if ($urandom_range(0, 63) == 0) begin
        send_item(make_item(ACT_INSERT, $urandom_range(1, 1 << 20), rand_offset()));
      end else begin
        next_stamp += $urandom_range(0, STAMP_STEP);
        send_item(make_item(ACT_INSERT, next_stamp, rand_offset()));
      end
    end
    send_item(make_item(ACT_INSERT, '0, rand_offset()));
    send_item(make_item(ACT_INSERT, '1, rand_offset()));
    send_item(make_item(ACT_INSERT, model_stamps[TABLE_DEPTH / 2], rand_offset()));
    send_item(make_item(ACT_LOOKUP, model_stamps[0], '0));
    send_item(make_item(ACT_LOOKUP, model_stamps[TABLE_DEPTH - 1], '0));
    send_item(make_item(ACT_LOOKUP, '1, '0));
    repeat (12) send_item(make_item(ACT_LOOKUP, pick_lookup_stamp(), rand_offset()));
    send_item(make_item(ACT_UNUSED, $urandom, rand_offset()));
    send_item(make_item(ACT_CLEAR, $urandom, rand_offset()));
  endtask

  task automatic test_backpressure_hold();
    // receiver holds off while items keep coming, so the input backs up
    hold_off_req = 1'b1;
    for (int k = 0; k < 30; k++) begin
      if (k % 3 == 2)
        send_item(make_item(ACT_LOOKUP, pick_lookup_stamp(), rand_offset()));
      else
        send_item(make_item(ACT_INSERT, k * STAMP_STEP, rand_offset()));
    end
    wait_drained();
  endtask

  task automatic test_random_sessions();
    int                 start;
    int                 run_len;
    logic [STAMP_W-1:0] next_stamp;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // well-formed session: a run of inserts with non-decreasing stamps, then mostly lookups against them
        if (model_count > 200 || $urandom_range(0, 3) == 0)
          send_item(make_item(ACT_CLEAR, $urandom, rand_offset()));
        if (model_count != 0 && $urandom_range(0, 1) == 0)
          next_stamp = model_stamps[model_count - 1];
        else if ($urandom_range(0, 1) == 0)
          next_stamp = $urandom;
        else
          next_stamp = $urandom_range(0, 1 << 20);
        run_len = $urandom_range(1, 40);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 7) != 0) next_stamp += STAMP_STEP;
          send_item(make_item(ACT_INSERT, next_stamp, rand_offset()));
        end
        run_len = $urandom_range(1, 20);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(make_item(ACT_INSERT, pick_lookup_stamp(), rand_offset()));
          else
            send_item(make_item(ACT_LOOKUP, pick_lookup_stamp(), rand_offset()));
        end
      end else begin
        run_len = $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++)
          send_item(make_item(2'($urandom_range(0, 3)), $urandom, rand_offset()));
      end
    end
  endtask

  // Receiver: stall pattern changes every so often; a hold-off request wins
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 300);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_tick % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: status %0d found_offset 'h%0h",
               out_data.status, out_data.found_offset);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.found_offset !== want.found_offset) begin
          $error("found_offset: expected 'h%0h, got 'h%0h",
                 want.found_offset, out_data.found_offset);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sorted_time_index_lookup: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_edges();
    wait_drained();
    test_fill_to_capacity();
    wait_drained();
    test_backpressure_hold();
    test_random_sessions();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("** sorted_time_index_lookup: PASSED **");
    else
      $display("** sorted_time_index_lookup: FAILED **");
    $finish;
  end

endmodule

[sorted_time_index_lookup.f]
+incdir+rtl
rtl/sti_pkg.sv
rtl/sti_mem.sv
rtl/sti_ctrl.sv
rtl/sorted_time_index_lookup.sv
rtl/sti_checker.sv
verif/testbench.sv
